// ----- src/rag_pkg.sv -----
package rag_pkg;

    localparam int unsigned DataWidth = 32;

    typedef enum logic [2:0] {
        K_ADD    = 3'd0,
        K_SUB    = 3'd1,
        K_MUL    = 3'd2,
        K_DIV    = 3'd3,
        K_REDUCE = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]  kind;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic signed [31:0] res_den;
        logic               error;
    } t_out_beat;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_SEL_A     = 4'd2,
        OP_SEL_B     = 4'd3,
        OP_STORE_A   = 4'd4,
        OP_STORE_B   = 4'd5,
        OP_NEG_B     = 4'd6,
        OP_MUL1      = 4'd7,
        OP_MUL2      = 4'd8,
        OP_SEL_R     = 4'd9,
        OP_GCD_START = 4'd10,
        OP_DIV_N     = 4'd11,
        OP_DIV_D     = 4'd12,
        OP_ADD_Q1    = 4'd13,
        OP_ADD_Q2    = 4'd14
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic y_zero;
        logic d_zero;
        logic g_zero;
        logic q_zero;
    } t_sts;

endpackage

// ----- src/rational_arith_gcd_reduce_core.sv -----
// operation: a zero input denominator ends the item with the error flag; otherwise
//   run time is set by the shared bit-serial divider (used for each gcd remainder step
//   and each reducing division; up to four reductions, plus two quotients for add and sub)
// throughput: one item at a time; next beat accepted once the result is registered
// reset: synchronous active low, clears controller state and output valid
module rational_arith_gcd_reduce_core
    import rag_pkg::*;
#(
    parameter int unsigned WIDTH = DataWidth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic [WIDTH-1:0] w_num, w_den;
    logic w_err, w_ov;
    t_in_beat r_in;
    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) r_in <= i_data;
    end

    rag_datapath #(.WIDTH(WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    ((i_valid && !o_stall) ? i_data : r_in),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    rag_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_kind  (r_in.kind),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_valid (w_ov),
        .i_stall (i_stall),
        .o_error (w_err)
    );

    always_ff @(posedge i_clk) begin
        if (!w_ov || !i_stall) begin
            r_out.res_num <= w_err ? '0 : 32'(signed'(w_num));
            r_out.res_den <= w_err ? '0 : 32'(signed'(w_den));
            r_out.error   <= w_err;
        end
    end

    assign o_valid = w_ov;
    assign o_data  = r_out;

endmodule

// ----- src/rag_divider.sv -----
module rag_divider
    import rag_pkg::*;
#(
    parameter int unsigned WIDTH = DataWidth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot,
    output logic [WIDTH-1:0] o_rem
);

    localparam int unsigned CntW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_q, n_q, r_r, n_r, r_d, n_d;
    logic             r_qneg, n_qneg, r_rneg, n_rneg;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [WIDTH:0]   w_trial;
    logic [WIDTH-1:0] w_shift;

    always_comb begin
        w_shift = {r_r[WIDTH-2:0], r_q[WIDTH-1]};
        w_trial = {1'b0, w_shift} - {1'b0, r_d};
    end

    always_comb begin
        n_q = r_q; n_r = r_r; n_d = r_d;
        n_qneg = r_qneg; n_rneg = r_rneg;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend[WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_d    = i_divisor[WIDTH-1] ? (~i_divisor + 1'b1) : i_divisor;
            n_r    = '0;
            n_qneg = i_dividend[WIDTH-1] ^ i_divisor[WIDTH-1];
            n_rneg = i_dividend[WIDTH-1];
            n_cnt  = CntW'(WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_r[WIDTH-1] || !w_trial[WIDTH]) begin
                n_r = w_trial[WIDTH-1:0];
                n_q = {r_q[WIDTH-2:0], 1'b1};
            end else begin
                n_r = w_shift;
                n_q = {r_q[WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d;
        r_qneg <= n_qneg; r_rneg <= n_rneg;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_qneg ? (~r_q + 1'b1) : r_q;
    assign o_rem  = r_rneg ? (~r_r + 1'b1) : r_r;

endmodule

// ----- src/rag_datapath.sv -----
module rag_datapath
    import rag_pkg::*;
#(
    parameter int unsigned WIDTH = DataWidth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic [WIDTH-1:0] o_num,
    output logic [WIDTH-1:0] o_den
);

    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd, r_n, r_d, r_x, r_y, r_rd, r_t;
    logic [WIDTH-1:0] w_dvd, w_dvs, w_quot, w_rem;
    logic             w_busy, w_done;

    rag_divider #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        unique case (i_cmd.op)
            OP_DIV_N:  begin w_dvd = r_n;  w_dvs = r_x; end
            OP_DIV_D:  begin w_dvd = r_d;  w_dvs = r_x; end
            OP_ADD_Q1: begin w_dvd = r_rd; w_dvs = r_ad; end
            OP_ADD_Q2: begin w_dvd = r_rd; w_dvs = r_bd; end
            default:   begin w_dvd = r_x;  w_dvs = r_y; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // gcd step: x <- y, y <- rem
        if (w_done && i_cmd.op == OP_GCD_START) begin
            r_x <= r_y;
            r_y <= w_rem;
        end
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_an <= WIDTH'(i_in.a_num); r_ad <= WIDTH'(i_in.a_den);
                r_bn <= WIDTH'(i_in.b_num); r_bd <= WIDTH'(i_in.b_den);
                r_n  <= WIDTH'(i_in.a_num); r_d  <= WIDTH'(i_in.a_den);
                r_x  <= WIDTH'(i_in.a_num); r_y  <= WIDTH'(i_in.a_den);
            end
            OP_SEL_A: begin r_n <= r_an; r_d <= r_ad; r_x <= r_an; r_y <= r_ad; end
            OP_SEL_B: begin r_n <= r_bn; r_d <= r_bd; r_x <= r_bn; r_y <= r_bd; end
            OP_SEL_R: begin r_x <= r_n; r_y <= r_d; end
            OP_STORE_A: begin r_an <= r_n; r_ad <= r_d; end
            OP_STORE_B: begin r_bn <= r_n; r_bd <= r_d; end
            OP_NEG_B: begin
                r_n <= ~r_bn + 1'b1; r_d <= r_bd;
                r_x <= ~r_bn + 1'b1; r_y <= r_bd;
            end
            OP_MUL1: begin
                unique case (t_kind'(i_in.kind))
                    K_DIV:   begin r_n <= WIDTH'(r_an * r_bd); r_d <= WIDTH'(r_ad * r_bn); end
                    K_MUL:   begin r_n <= WIDTH'(r_an * r_bn); r_d <= WIDTH'(r_ad * r_bd); end
                    K_ADD, K_SUB: r_rd <= WIDTH'(r_ad * r_bd);
                    default: begin r_n <= r_an; r_d <= r_ad; end
                endcase
            end
            OP_MUL2: begin
                r_d <= r_rd;
                r_n <= WIDTH'(r_t + WIDTH'(w_quot * r_bn));
            end
            OP_ADD_Q1: if (w_done) r_t <= WIDTH'(w_quot * r_an);
            OP_DIV_N:  if (w_done) r_n <= w_quot;
            OP_DIV_D:  if (w_done) r_d <= w_quot;
            default: ;
        endcase
    end

    assign o_sts.div_busy = w_busy;
    assign o_sts.div_done = w_done;
    assign o_sts.y_zero   = (r_y == '0);
    assign o_sts.d_zero   = (r_d == '0);
    assign o_sts.g_zero   = (r_x == '0);
    assign o_sts.q_zero   = (w_quot == '0);
    assign o_num = r_n;
    assign o_den = r_d;

endmodule

// ----- src/rag_ctrl.sv -----
module rag_ctrl
    import rag_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  logic [2:0] i_kind,
    input  t_sts  i_sts,
    output t_cmd  o_cmd,
    output logic  o_valid,
    input  logic  i_stall,
    output logic  o_error
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SEL   = 10'b0000000010,
        S_GCD   = 10'b0000000100,
        S_DIVN  = 10'b0000001000,
        S_DIVD  = 10'b0000010000,
        S_NEXT  = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_Q1    = 10'b0010000000,
        S_Q2    = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    // phase: 0 a, 1 b, 2 neg b, 3 result
    t_state r_st, n_st;
    logic [1:0] r_ph, n_ph;
    logic r_run, n_run, r_err, n_err, w_kind_ok;
    logic r_ov, n_ov;
    logic r_pend_sel, n_pend_sel;

    assign w_kind_ok = (i_kind <= 3'(K_DIV));

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_run = 1'b0; n_err = r_err; n_ov = r_ov;
        o_cmd.op = OP_NONE; o_cmd.div_start = 1'b0;
        if (r_ov && !i_stall) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: if (i_valid) begin
                o_cmd.op = OP_LOAD; n_ph = 2'd0; n_err = 1'b0; n_st = S_SEL;
            end
            S_SEL: begin
                if (r_pend_sel) begin
                    // load the operand of this phase
                    unique case (r_ph)
                        2'd1:    o_cmd.op = OP_SEL_B;
                        2'd2:    o_cmd.op = OP_NEG_B;
                        default: o_cmd.op = OP_SEL_R;
                    endcase
                end else if (i_sts.d_zero) begin
                    n_err = 1'b1; n_st = S_OUT;
                end else begin
                    o_cmd.op = OP_GCD_START; n_st = S_GCD;
                end
            end
            S_GCD: begin
                o_cmd.op = OP_GCD_START;
                if (!i_sts.div_busy && !r_run) begin
                    if (i_sts.y_zero) begin
                        if (i_sts.g_zero) n_st = S_NEXT;
                        else begin o_cmd.op = OP_DIV_N; o_cmd.div_start = 1'b1;
                            n_st = S_DIVN; end
                    end else begin
                        o_cmd.div_start = 1'b1; n_run = 1'b1;
                    end
                end else if (i_sts.div_busy) n_run = 1'b1;
            end
            S_DIVN: begin
                o_cmd.op = OP_DIV_N;
                if (i_sts.div_done) begin
                    o_cmd.op = OP_DIV_N; n_st = S_DIVD;
                end
            end
            S_DIVD: begin
                o_cmd.op = OP_DIV_D;
                if (!i_sts.div_busy && !r_run) begin
                    o_cmd.div_start = 1'b1; n_run = 1'b1;
                end else if (i_sts.div_busy) n_run = 1'b1;
                else if (i_sts.div_done) begin
                    if (i_sts.q_zero) begin n_err = 1'b1; n_st = S_OUT; end
                    else n_st = S_NEXT;
                end
            end
            S_NEXT: begin
                unique case (r_ph)
                    2'd0: begin
                        o_cmd.op = OP_STORE_A;
                        if (w_kind_ok) begin n_ph = 2'd1; n_st = S_SEL; end
                        else n_st = S_MUL;
                    end
                    2'd1: begin
                        o_cmd.op = OP_STORE_B;
                        if (i_kind == 3'(K_SUB)) begin n_ph = 2'd2; n_st = S_SEL; end
                        else n_st = S_MUL;
                    end
                    2'd2: begin o_cmd.op = OP_STORE_B; n_st = S_MUL; end
                    default: begin n_st = S_OUT; end
                endcase
            end
            S_MUL: begin
                o_cmd.op = OP_MUL1; n_ph = 2'd3;
                if (i_kind == 3'(K_ADD) || i_kind == 3'(K_SUB)) n_st = S_Q1;
                else n_st = S_SEL;
            end
            S_Q1: begin
                o_cmd.op = OP_ADD_Q1;
                if (!i_sts.div_busy && !r_run) begin
                    o_cmd.div_start = 1'b1; n_run = 1'b1;
                end else if (i_sts.div_busy) n_run = 1'b1;
                else if (i_sts.div_done) n_st = S_Q2;
            end
            S_Q2: begin
                o_cmd.op = OP_ADD_Q2;
                if (!i_sts.div_busy && !r_run) begin
                    o_cmd.div_start = 1'b1; n_run = 1'b1;
                end else if (i_sts.div_busy) n_run = 1'b1;
                else if (i_sts.div_done) begin
                    o_cmd.op = OP_MUL2; n_st = S_SEL;
                end
            end
            S_OUT: if (!r_ov || !i_stall) begin
                n_ov = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
        // operand load pending on entry to a later reduction
        n_pend_sel = (n_st == S_SEL) && (r_st != S_SEL) && (r_st != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ph <= '0; r_run <= 1'b0; r_err <= 1'b0; r_ov <= 1'b0;
            r_pend_sel <= 1'b0;
        end else begin
            r_st <= n_st; r_ph <= n_ph; r_run <= n_run; r_err <= n_err; r_ov <= n_ov;
            r_pend_sel <= n_pend_sel;
        end
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_error = r_err;

endmodule
